// ===== rtl/lcx_pkg.sv =====
// Shared types, constants and the power table builder for the lux calculator.
package lcx_pkg;

   localparam int POW_TABLE_ENTRIES = 256;

   localparam int CNT_W      = 16;
   localparam int LUX_W      = 15;
   localparam int SEG_W      = 3;
   localparam int RATIO_W    = 16;
   localparam int FRAC_W     = 15;
   localparam int POW_W      = 16;
   localparam int POW_IDX_W  = $clog2(POW_TABLE_ENTRIES + 1);
   localparam int POS_W      = FRAC_W + POW_IDX_W;
   localparam int COEF_W     = 20;
   localparam int CMP_W      = 24;
   localparam int LIN_W      = 35;
   localparam int PROD_W     = 2 * CNT_W;
   localparam int WIDE_W     = COEF_W + PROD_W;
   localparam int SUB_SHIFT  = 16;
   localparam int SUB_W      = WIDE_W - SUB_SHIFT;
   localparam int D_W        = 37;
   localparam int LUX_FRAC   = 20;
   localparam int LUXQ_W     = D_W - LUX_FRAC;
   localparam int DIV_STEPS  = 2;
   localparam int DIV_STAGES = RATIO_W / DIV_STEPS;

   // Lux coefficients in Q24.
   localparam logic [COEF_W-1:0] COEF_A1 = 20'd510027;
   localparam logic [COEF_W-1:0] COEF_B1 = 20'd1040187;
   localparam logic [COEF_W-1:0] COEF_A2 = 20'd375810;
   localparam logic [COEF_W-1:0] COEF_B2 = 20'd520094;
   localparam logic [COEF_W-1:0] COEF_A3 = 20'd214748;
   localparam logic [COEF_W-1:0] COEF_B3 = 20'd256691;
   localparam logic [COEF_W-1:0] COEF_A4 = 20'd24495;
   localparam logic [COEF_W-1:0] COEF_B4 = 20'd18790;

   // Ratio breakpoints in hundredths.
   localparam logic [7:0] RATIO_SCALE = 8'd100;
   localparam logic [7:0] BREAK_1     = 8'd50;
   localparam logic [7:0] BREAK_2     = 8'd61;
   localparam logic [7:0] BREAK_3     = 8'd80;
   localparam logic [7:0] BREAK_4     = 8'd130;

   localparam logic [LUX_W-1:0] LUX_MAX = '1;

   typedef enum logic [SEG_W-1:0] {
      SEG_NONE  = 3'd0,
      SEG_ONE   = 3'd1,
      SEG_TWO   = 3'd2,
      SEG_THREE = 3'd3,
      SEG_FOUR  = 3'd4,
      SEG_OVER  = 3'd5
   } seg_type;

   typedef struct packed {
      seg_type             seg;
      logic [CNT_W-1:0]    ch0;
      logic [LIN_W-1:0]    pa;
      logic [LIN_W-1:0]    pb;
   } side_type;

   typedef struct packed {
      logic [CNT_W-1:0] ch1;
      side_type         side;
   } front_type;

   typedef logic [POW_TABLE_ENTRIES:0][POW_W-1:0] pow_rom_type;

   // Entry i holds x^1.4 in Q16 at x = floor(i * 32768 / N) / 2^16, built from
   // the integer fifth root of x^2 (x^0.4 in Q13).
   function automatic pow_rom_type build_pow_rom();
      pow_rom_type       rom;
      longint unsigned   u;
      longint unsigned   target;
      longint unsigned   lo;
      longint unsigned   hi;
      longint unsigned   mid;
      for (int i = 0; i <= POW_TABLE_ENTRIES; i++) begin
         u      = (longint'(i) * 64'd32768) / POW_TABLE_ENTRIES;
         target = (u * u) << 33;
         lo     = 0;
         hi     = 6300;
         for (int j = 0; j < 16; j++) begin
            if (lo < hi) begin
               mid = (lo + hi + 1) >> 1;
               if (mid * mid * mid * mid * mid <= target) begin
                  lo = mid;
               end else begin
                  hi = mid - 1;
               end
            end
         end
         rom[i] = POW_W'((u * lo) >> 13);
      end
      return rom;
   endfunction

endpackage

// ===== rtl/two_channel_lux_calculator.sv =====
// Top level of the two-channel ambient light lux calculator.
//
// Each request transaction carries a broadband (visible plus infrared) count and
// an infrared count from a two-channel light sensor; each response transaction
// carries the illuminance in sixteenths of a lux and the formula segment used.
// The ratio ch1/ch0 selects one of four linear segments with breakpoints at 0.50,
// 0.61, 0.80 and 1.30, tested exactly on the integer counts. The lowest segment
// uses r^1.4, taken from an interpolated power table, with r = ch1/ch0 formed by
// a pipelined divider. Segment 0 reports a zero count on either channel,
// segment 5 a ratio above 1.30; both give zero lux, and a negative result
// clamps to zero. The pipeline holds 17 register stages: two for classification
// and the linear products, eight divider stages that each retire two quotient
// bits, five for the table lookup, interpolation and the two multiplies of the
// curved term, and two for the final sum and the clamp. It takes one
// transaction per clock and gives one result per cycle while the response
// side does not stall. Every stage has its own valid bit and is refilled as
// soon as it empties, so a stall on the response side loses nothing, and empty
// stages keep accepting requests while a finished result waits at the output.
module two_channel_lux_calculator
   import lcx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] broadband_count, [31:16] infrared_count
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [14:0] lux_sixteenths, [15] zero
   output logic [2:0]  rsp_tuser    // [2:0] segment
);

   // Front end to divider.
   logic      fr_valid;
   logic      fr_ready;
   front_type fr_item;

   // Divider to power lookup.
   logic               dv_valid;
   logic               dv_ready;
   logic [RATIO_W-1:0] dv_ratio;
   side_type           dv_side;

   // Power lookup to tail.
   logic             pw_valid;
   logic             pw_ready;
   logic [SUB_W-1:0] pw_sub;
   side_type         pw_side;

   logic [LUX_W-1:0] lux;
   seg_type          seg;

   // Classify the ratio segment and form a*ch0 and b*ch1.
   lcx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_ch0    (req_tdata[CNT_W-1:0]),
      .in_ch1    (req_tdata[2*CNT_W-1:CNT_W]),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_item  (fr_item)
   );

   // Q16 ratio ch1/ch0; only meaningful for the lowest segment.
   lcx_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_item   (fr_item),
      .out_valid (dv_valid),
      .out_ready (dv_ready),
      .out_ratio (dv_ratio),
      .out_side  (dv_side)
   );

   // r^1.4 by table and the curved term 0.062 * ch0 * r^1.4.
   lcx_pow u_pow (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dv_valid),
      .in_ready  (dv_ready),
      .in_ratio  (dv_ratio),
      .in_side   (dv_side),
      .out_valid (pw_valid),
      .out_ready (pw_ready),
      .out_sub   (pw_sub),
      .out_side  (pw_side)
   );

   // Final difference, shift to sixteenths, clamp; the output register lives here.
   lcx_tail u_tail (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pw_valid),
      .in_ready  (pw_ready),
      .in_sub    (pw_sub),
      .in_side   (pw_side),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_lux   (lux),
      .out_seg   (seg)
   );

   assign rsp_tdata = {1'b0, lux};
   assign rsp_tuser = seg;

endmodule

// ===== rtl/lcx_front.sv =====
// Front stages: segment classification and the linear lux products.
module lcx_front
   import lcx_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [CNT_W-1:0] in_ch0,
   input  logic [CNT_W-1:0] in_ch1,
   output logic             out_valid,
   input  logic             out_ready,
   output front_type        out_item
);

   logic             cls_vld_ff, cls_vld_in;
   logic [CNT_W-1:0] cls_ch0_ff, cls_ch0_in;
   logic [CNT_W-1:0] cls_ch1_ff, cls_ch1_in;
   seg_type          cls_seg_ff, cls_seg_in;
   logic             prd_vld_ff, prd_vld_in;
   front_type        prd_item_ff, prd_item_in;
   logic             cls_ready;
   logic             prd_ready;
   logic [CMP_W-1:0] scaled_ch1;
   logic [COEF_W-1:0] a_sel;
   logic [COEF_W-1:0] b_sel;
   seg_type          seg_new;

   assign prd_ready = !prd_vld_ff || out_ready;
   assign cls_ready = !cls_vld_ff || prd_ready;
   assign in_ready  = cls_ready;
   assign out_valid = prd_vld_ff;
   assign out_item  = prd_item_ff;

   // Each breakpoint is an exact test of ch1 * 100 <= K * ch0.
   always_comb begin
      scaled_ch1 = CMP_W'(in_ch1) * CMP_W'(RATIO_SCALE);
      if (in_ch0 == '0 || in_ch1 == '0) begin
         seg_new = SEG_NONE;
      end else if (scaled_ch1 <= CMP_W'(in_ch0) * CMP_W'(BREAK_1)) begin
         seg_new = SEG_ONE;
      end else if (scaled_ch1 <= CMP_W'(in_ch0) * CMP_W'(BREAK_2)) begin
         seg_new = SEG_TWO;
      end else if (scaled_ch1 <= CMP_W'(in_ch0) * CMP_W'(BREAK_3)) begin
         seg_new = SEG_THREE;
      end else if (scaled_ch1 <= CMP_W'(in_ch0) * CMP_W'(BREAK_4)) begin
         seg_new = SEG_FOUR;
      end else begin
         seg_new = SEG_OVER;
      end

      cls_vld_in = cls_vld_ff;
      cls_ch0_in = cls_ch0_ff;
      cls_ch1_in = cls_ch1_ff;
      cls_seg_in = cls_seg_ff;
      if (cls_ready) begin
         cls_vld_in = in_valid;
         cls_ch0_in = in_ch0;
         cls_ch1_in = in_ch1;
         cls_seg_in = seg_new;
      end
   end

   // Segment one only takes its a*ch0 term here; its curved term comes later.
   always_comb begin
      case (cls_seg_ff)
         SEG_ONE: begin
            a_sel = COEF_A1;
            b_sel = '0;
         end
         SEG_TWO: begin
            a_sel = COEF_A2;
            b_sel = COEF_B2;
         end
         SEG_THREE: begin
            a_sel = COEF_A3;
            b_sel = COEF_B3;
         end
         SEG_FOUR: begin
            a_sel = COEF_A4;
            b_sel = COEF_B4;
         end
         default: begin
            a_sel = '0;
            b_sel = '0;
         end
      endcase

      prd_vld_in  = prd_vld_ff;
      prd_item_in = prd_item_ff;
      if (prd_ready) begin
         prd_vld_in           = cls_vld_ff;
         prd_item_in.ch1      = cls_ch1_ff;
         prd_item_in.side.seg = cls_seg_ff;
         prd_item_in.side.ch0 = cls_ch0_ff;
         prd_item_in.side.pa  = LIN_W'(a_sel) * LIN_W'(cls_ch0_ff);
         prd_item_in.side.pb  = LIN_W'(b_sel) * LIN_W'(cls_ch1_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cls_vld_ff <= 1'b0;
         prd_vld_ff <= 1'b0;
      end else begin
         cls_vld_ff <= cls_vld_in;
         prd_vld_ff <= prd_vld_in;
      end
      cls_ch0_ff  <= cls_ch0_in;
      cls_ch1_ff  <= cls_ch1_in;
      cls_seg_ff  <= cls_seg_in;
      prd_item_ff <= prd_item_in;
   end

endmodule

// ===== rtl/lcx_div.sv =====
// Pipelined restoring divider for the Q16 ratio ch1 / ch0, two quotient bits per stage.
module lcx_div
   import lcx_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  front_type          in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [RATIO_W-1:0] out_ratio,
   output side_type           out_side
);

   logic [DIV_STAGES-1:0] vld_ff, vld_in;
   logic [DIV_STAGES:0]   rdy;
   logic [CNT_W-1:0]      rem_ff  [DIV_STAGES];
   logic [CNT_W-1:0]      rem_in  [DIV_STAGES];
   logic [RATIO_W-1:0]    quo_ff  [DIV_STAGES];
   logic [RATIO_W-1:0]    quo_in  [DIV_STAGES];
   side_type              side_ff [DIV_STAGES];
   side_type              side_in [DIV_STAGES];

   always_comb begin
      rdy[DIV_STAGES] = out_ready;
      for (int k = DIV_STAGES - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[DIV_STAGES-1];
   assign out_ratio = quo_ff[DIV_STAGES-1];
   assign out_side  = side_ff[DIV_STAGES-1];

   // The ratio is only used when ch1 < ch0, so the remainder starts at ch1 and
   // the leading quotient bits are all zero.
   always_comb begin
      logic               src_vld;
      logic [CNT_W-1:0]   rem_t;
      logic [RATIO_W-1:0] quo_t;
      side_type           side_t;
      logic [CNT_W:0]     trial;
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (k == 0) begin
            src_vld = in_valid;
            rem_t   = in_item.ch1;
            quo_t   = '0;
            side_t  = in_item.side;
         end else begin
            src_vld = vld_ff[k-1];
            rem_t   = rem_ff[k-1];
            quo_t   = quo_ff[k-1];
            side_t  = side_ff[k-1];
         end
         for (int j = 0; j < DIV_STEPS; j++) begin
            trial = {rem_t, 1'b0};
            if (trial >= {1'b0, side_t.ch0}) begin
               trial = trial - {1'b0, side_t.ch0};
               quo_t = {quo_t[RATIO_W-2:0], 1'b1};
            end else begin
               quo_t = {quo_t[RATIO_W-2:0], 1'b0};
            end
            rem_t = trial[CNT_W-1:0];
         end
         if (rdy[k]) begin
            vld_in[k]  = src_vld;
            rem_in[k]  = rem_t;
            quo_in[k]  = quo_t;
            side_in[k] = side_t;
         end else begin
            vld_in[k]  = vld_ff[k];
            rem_in[k]  = rem_ff[k];
            quo_in[k]  = quo_ff[k];
            side_in[k] = side_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      side_ff <= side_in;
   end

endmodule

// ===== rtl/lcx_pow.sv =====
// Power table lookup with interpolation and the curved term of segment one.
module lcx_pow
   import lcx_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [RATIO_W-1:0] in_ratio,
   input  side_type           in_side,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [SUB_W-1:0]   out_sub,
   output side_type           out_side
);

   localparam pow_rom_type POW_ROM = build_pow_rom();
   localparam logic [POW_IDX_W-1:0] IDX_LAST = POW_IDX_W'(POW_TABLE_ENTRIES);

   // Stage 1: table position.
   logic                 pos_vld_ff, pos_vld_in;
   logic [POW_IDX_W-1:0] pos_lo_ff, pos_lo_in;
   logic [POW_IDX_W-1:0] pos_hi_ff, pos_hi_in;
   logic [FRAC_W-1:0]    pos_frac_ff, pos_frac_in;
   side_type             pos_side_ff, pos_side_in;
   // Stage 2: table read.
   logic                 rom_vld_ff, rom_vld_in;
   logic [POW_W-1:0]     rom_a_ff;
   logic [POW_W-1:0]     rom_b_ff;
   logic [FRAC_W-1:0]    rom_frac_ff, rom_frac_in;
   side_type             rom_side_ff, rom_side_in;
   // Stage 3: interpolated power.
   logic                 itp_vld_ff, itp_vld_in;
   logic [POW_W-1:0]     itp_p_ff, itp_p_in;
   side_type             itp_side_ff, itp_side_in;
   // Stage 4: ch0 times power.
   logic                 cpp_vld_ff, cpp_vld_in;
   logic [PROD_W-1:0]    cpp_val_ff, cpp_val_in;
   side_type             cpp_side_ff, cpp_side_in;
   // Stage 5: scaled curved term.
   logic                 sub_vld_ff, sub_vld_in;
   logic [SUB_W-1:0]     sub_val_ff, sub_val_in;
   side_type             sub_side_ff, sub_side_in;

   logic pos_ready, rom_ready, itp_ready, cpp_ready, sub_ready;

   logic [POS_W-1:0]          pos;
   logic [POW_IDX_W-1:0]      idx;
   logic [POW_W-1:0]          diff;
   logic [POW_W+FRAC_W-1:0]   step;
   logic [WIDE_W-1:0]         wide;

   assign sub_ready = !sub_vld_ff || out_ready;
   assign cpp_ready = !cpp_vld_ff || sub_ready;
   assign itp_ready = !itp_vld_ff || cpp_ready;
   assign rom_ready = !rom_vld_ff || itp_ready;
   assign pos_ready = !pos_vld_ff || rom_ready;
   assign in_ready  = pos_ready;

   assign out_valid = sub_vld_ff;
   assign out_sub   = sub_val_ff;
   assign out_side  = sub_side_ff;

   always_comb begin
      pos = POS_W'(in_ratio) * POS_W'(POW_TABLE_ENTRIES);
      idx = pos[POS_W-1:FRAC_W];
      if (idx >= IDX_LAST) begin
         idx = IDX_LAST;
      end

      pos_vld_in  = pos_vld_ff;
      pos_lo_in   = pos_lo_ff;
      pos_hi_in   = pos_hi_ff;
      pos_frac_in = pos_frac_ff;
      pos_side_in = pos_side_ff;
      if (pos_ready) begin
         pos_vld_in  = in_valid;
         pos_lo_in   = idx;
         pos_hi_in   = (idx == IDX_LAST) ? idx : idx + POW_IDX_W'(1);
         pos_frac_in = pos[FRAC_W-1:0];
         pos_side_in = in_side;
      end
   end

   always_comb begin
      rom_vld_in  = rom_vld_ff;
      rom_frac_in = rom_frac_ff;
      rom_side_in = rom_side_ff;
      if (rom_ready) begin
         rom_vld_in  = pos_vld_ff;
         rom_frac_in = pos_frac_ff;
         rom_side_in = pos_side_ff;
      end
   end

   // Two registered reads of the table per cycle while the read stage can advance.
   always_ff @(posedge clock) begin
      if (rom_ready) begin
         rom_a_ff <= POW_ROM[pos_lo_ff];
         rom_b_ff <= POW_ROM[pos_hi_ff];
      end
   end

   // A falling table step keeps the lower entry.
   always_comb begin
      diff = (rom_b_ff > rom_a_ff) ? rom_b_ff - rom_a_ff : '0;
      step = (POW_W + FRAC_W)'(diff) * (POW_W + FRAC_W)'(rom_frac_ff);

      itp_vld_in  = itp_vld_ff;
      itp_p_in    = itp_p_ff;
      itp_side_in = itp_side_ff;
      if (itp_ready) begin
         itp_vld_in  = rom_vld_ff;
         itp_p_in    = rom_a_ff + step[POW_W+FRAC_W-1:FRAC_W];
         itp_side_in = rom_side_ff;
      end
   end

   always_comb begin
      cpp_vld_in  = cpp_vld_ff;
      cpp_val_in  = cpp_val_ff;
      cpp_side_in = cpp_side_ff;
      if (cpp_ready) begin
         cpp_vld_in  = itp_vld_ff;
         cpp_val_in  = PROD_W'(itp_side_ff.ch0) * PROD_W'(itp_p_ff);
         cpp_side_in = itp_side_ff;
      end
   end

   always_comb begin
      wide = WIDE_W'(COEF_B1) * WIDE_W'(cpp_val_ff);

      sub_vld_in  = sub_vld_ff;
      sub_val_in  = sub_val_ff;
      sub_side_in = sub_side_ff;
      if (sub_ready) begin
         sub_vld_in  = cpp_vld_ff;
         sub_val_in  = wide[WIDE_W-1:SUB_SHIFT];
         sub_side_in = cpp_side_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_vld_ff <= 1'b0;
         rom_vld_ff <= 1'b0;
         itp_vld_ff <= 1'b0;
         cpp_vld_ff <= 1'b0;
         sub_vld_ff <= 1'b0;
      end else begin
         pos_vld_ff <= pos_vld_in;
         rom_vld_ff <= rom_vld_in;
         itp_vld_ff <= itp_vld_in;
         cpp_vld_ff <= cpp_vld_in;
         sub_vld_ff <= sub_vld_in;
      end
      pos_lo_ff   <= pos_lo_in;
      pos_hi_ff   <= pos_hi_in;
      pos_frac_ff <= pos_frac_in;
      pos_side_ff <= pos_side_in;
      rom_frac_ff <= rom_frac_in;
      rom_side_ff <= rom_side_in;
      itp_p_ff    <= itp_p_in;
      itp_side_ff <= itp_side_in;
      cpp_val_ff  <= cpp_val_in;
      cpp_side_ff <= cpp_side_in;
      sub_val_ff  <= sub_val_in;
      sub_side_ff <= sub_side_in;
   end

endmodule

// ===== rtl/lcx_tail.sv =====
// Tail stages: signed Q24 lux sum, then scaling to sixteenths with clamping.
module lcx_tail
   import lcx_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [SUB_W-1:0] in_sub,
   input  side_type         in_side,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [LUX_W-1:0] out_lux,
   output seg_type          out_seg
);

   logic             dif_vld_ff, dif_vld_in;
   logic [D_W-1:0]   dif_d_ff, dif_d_in;
   seg_type          dif_seg_ff, dif_seg_in;
   logic             res_vld_ff, res_vld_in;
   logic [LUX_W-1:0] res_lux_ff, res_lux_in;
   seg_type          res_seg_ff, res_seg_in;
   logic             dif_ready;
   logic             res_ready;
   logic [LUXQ_W-1:0] lux_q;

   assign res_ready = !res_vld_ff || out_ready;
   assign dif_ready = !dif_vld_ff || res_ready;
   assign in_ready  = dif_ready;
   assign out_valid = res_vld_ff;
   assign out_lux   = res_lux_ff;
   assign out_seg   = res_seg_ff;

   // Segments without a formula carry zero products, so they give zero here.
   always_comb begin
      dif_vld_in = dif_vld_ff;
      dif_d_in   = dif_d_ff;
      dif_seg_in = dif_seg_ff;
      if (dif_ready) begin
         dif_vld_in = in_valid;
         dif_d_in   = D_W'(in_side.pa) - D_W'(in_side.pb)
                      - ((in_side.seg == SEG_ONE) ? D_W'(in_sub) : D_W'(0));
         dif_seg_in = in_side.seg;
      end
   end

   always_comb begin
      lux_q      = dif_d_ff[D_W-1:LUX_FRAC];
      res_vld_in = res_vld_ff;
      res_lux_in = res_lux_ff;
      res_seg_in = res_seg_ff;
      if (res_ready) begin
         res_vld_in = dif_vld_ff;
         res_seg_in = dif_seg_ff;
         if (dif_d_ff[D_W-1] || dif_d_ff == '0) begin
            res_lux_in = '0;
         end else if (lux_q > LUXQ_W'(LUX_MAX)) begin
            res_lux_in = LUX_MAX;
         end else begin
            res_lux_in = lux_q[LUX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dif_vld_ff <= 1'b0;
         res_vld_ff <= 1'b0;
      end else begin
         dif_vld_ff <= dif_vld_in;
         res_vld_ff <= res_vld_in;
      end
      dif_d_ff   <= dif_d_in;
      dif_seg_ff <= dif_seg_in;
      res_lux_ff <= res_lux_in;
      res_seg_ff <= res_seg_in;
   end

endmodule
